// ----- src/wdns_pkg.sv -----
// ----------------------------------------------------------------------------
// wdns_pkg
// Shared types, constants and calendar helpers of the weekly day/night
// scheduler.
// ----------------------------------------------------------------------------
package wdns_pkg;

    // Field widths
    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DOM_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int WDAY_W   = 3;
    localparam int MOD_W    = 11;   // minute of day
    localparam int DOY_W    = 9;    // day of year
    localparam int CFG_W    = 44;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 48;

    // First year counted by the year walk
    localparam logic [YEAR_W-1:0] BASE_YEAR = 7'd8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DAYS_0_1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAYS_2_3  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAYS_4_5  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_6     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_SP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_SP  = 3'd6;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture the input word
        logic step;     // advance the year walk by one year
        logic finish;   // decide mode and load the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic walk_done;    // all whole years added
        logic out_blocked;  // output register full and not taken
    } t_status;

    // Days before the first of a month (1..12); month is known valid
    function automatic logic [DOY_W-1:0] f_month_offset(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] off;
        unique case (month)
            4'd1:    off = 9'd0;
            4'd2:    off = 9'd31;
            4'd3:    off = 9'd59;
            4'd4:    off = 9'd90;
            4'd5:    off = 9'd120;
            4'd6:    off = 9'd151;
            4'd7:    off = 9'd181;
            4'd8:    off = 9'd212;
            4'd9:    off = 9'd243;
            4'd10:   off = 9'd273;
            4'd11:   off = 9'd304;
            4'd12:   off = 9'd334;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // Residue mod 7 of a day-of-year value (8 = 1 mod 7, fold octal digits)
    function automatic logic [WDAY_W-1:0] f_mod7(input logic [DOY_W-1:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = 5'(v[8:6]) + 5'(v[5:3]) + 5'(v[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
        return r[WDAY_W-1:0];
    endfunction

endpackage

// ----- src/wdns_ctrl.sv -----
// ----------------------------------------------------------------------------
// wdns_ctrl
// Controller of the scheduler: accepts a word, runs the year walk, then
// hands the decision to the output register once it is free.
// ----------------------------------------------------------------------------
module wdns_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wdns_pkg::t_status  i_status,
    output wdns_pkg::t_cmd     o_cmd
);

    wdns_pkg::t_state r_state;
    wdns_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wdns_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            wdns_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = wdns_pkg::ST_WALK;
                end
            end
            wdns_pkg::ST_WALK: begin
                if (!i_status.walk_done) begin
                    o_cmd.step = 1'b1;
                end else if (!i_status.out_blocked) begin
                    o_cmd.finish = 1'b1;
                    n_state      = wdns_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wdns_pkg::ST_IDLE;
            end
        endcase
    end

    // Never take a word while one is in work
    a_no_accept_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wdns_pkg::ST_WALK) |-> !o_in_ready)
        else $error("input taken during year walk");

    // A load always starts a walk
    a_load_enters_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == wdns_pkg::ST_WALK))
        else $error("load did not start walk");

    // Finish only after the walk has ended and the output is free
    a_finish_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (i_status.walk_done && !i_status.out_blocked && !o_cmd.step))
        else $error("finish issued early");

endmodule

// ----- src/wdns_dp.sv -----
// ----------------------------------------------------------------------------
// wdns_dp
// Datapath of the scheduler: configuration registers, weekday residue with
// the year walk, day/night decision, stored mode and the output register.
// ----------------------------------------------------------------------------
module wdns_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wdns_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wdns_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [wdns_pkg::IN_W-1:0]         i_in_data,
    input  wdns_pkg::t_cmd                    i_cmd,
    output wdns_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wdns_pkg::OUT_W-1:0]        o_out_data
);

    // Configuration registers
    logic [43:0] r_days_0_1;
    logic [43:0] r_days_2_3;
    logic [43:0] r_days_4_5;
    logic [21:0] r_day_6;
    logic [10:0] r_control;
    logic [39:0] r_day_sp;
    logic [39:0] r_night_sp;

    // Work registers
    logic [wdns_pkg::YEAR_W-1:0] r_year;
    logic [wdns_pkg::YEAR_W-1:0] r_yidx;
    logic [wdns_pkg::WDAY_W-1:0] r_res;
    logic [wdns_pkg::MOD_W-1:0]  r_now;
    logic                        r_night;

    // Output register
    logic                        r_out_valid;
    logic [wdns_pkg::WDAY_W-1:0] r_out_wday;
    logic                        r_out_night;
    logic                        r_out_changed;
    logic                        r_out_temp_upd;
    logic [15:0]                 r_out_temp;
    logic                        r_out_fan_upd;
    logic [15:0]                 r_out_fan;
    logic                        r_out_cm_upd;
    logic [7:0]                  r_out_cm;

    // Input fields
    logic [wdns_pkg::YEAR_W-1:0]  in_year;
    logic [wdns_pkg::MONTH_W-1:0] in_month;
    logic [wdns_pkg::DOM_W-1:0]   in_dom;
    logic [wdns_pkg::HOUR_W-1:0]  in_hour;
    logic [wdns_pkg::MIN_W-1:0]   in_min;

    logic                         leap;
    logic                         month_ok;
    logic [wdns_pkg::DOY_W-1:0]   doy;
    logic [wdns_pkg::MOD_W-1:0]   now_in;
    logic [3:0]                   step_sum;
    logic [wdns_pkg::WDAY_W-1:0]  step_res;
    logic [21:0]                  win;
    logic                         day_en;
    logic                         next_night;
    logic                         manual;
    logic                         changed;
    logic [39:0]                  sp;

    assign in_year  = i_in_data[6:0];
    assign in_month = i_in_data[10:7];
    assign in_dom   = i_in_data[15:11];
    assign in_hour  = i_in_data[20:16];
    assign in_min   = i_in_data[26:21];

    // Day of year; a bad month counts the whole year without the date
    assign leap     = (in_year[1:0] == 2'b00);
    assign month_ok = (in_month >= 4'd1) && (in_month <= 4'd12);
    always_comb begin
        if (month_ok) begin
            doy = wdns_pkg::f_month_offset(in_month) + 9'(in_dom)
                + 9'(leap && (in_month > 4'd2));
        end else begin
            doy = 9'd365 + 9'(leap);
        end
    end

    // Minute of day: hour*60 as hour*64 - hour*4
    assign now_in = 11'({in_hour, 6'd0}) - 11'({in_hour, 2'd0}) + 11'(in_min);

    // One year of the walk: 365 = 1 mod 7, a leap year adds one more
    assign o_status.walk_done   = (r_yidx >= r_year);
    assign o_status.out_blocked = r_out_valid && !i_out_ready;
    assign step_sum = 4'(r_res) + ((r_yidx[1:0] == 2'b00) ? 4'd2 : 4'd1);
    assign step_res = (step_sum >= 4'd7) ? 3'(step_sum - 4'd7) : step_sum[2:0];

    // Pick the window and enable of the weekday (residue 0 is Monday)
    always_comb begin
        unique case (r_res)
            3'd0:    win = r_days_0_1[21:0];
            3'd1:    win = r_days_0_1[43:22];
            3'd2:    win = r_days_2_3[21:0];
            3'd3:    win = r_days_2_3[43:22];
            3'd4:    win = r_days_4_5[21:0];
            3'd5:    win = r_days_4_5[43:22];
            default: win = r_day_6;
        endcase
        unique case (r_res)
            3'd0:    day_en = r_control[1];
            3'd1:    day_en = r_control[2];
            3'd2:    day_en = r_control[3];
            3'd3:    day_en = r_control[4];
            3'd4:    day_en = r_control[5];
            3'd5:    day_en = r_control[6];
            default: day_en = r_control[7];
        endcase
    end

    // Day when enabled and start <= now < end
    assign next_night = !(day_en && (r_now >= win[10:0]) && (r_now < win[21:11]));
    assign manual     = r_control[0];
    assign changed    = !manual && (next_night != r_night);
    assign sp         = next_night ? r_night_sp : r_day_sp;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_days_0_1 <= '0;
            r_days_2_3 <= '0;
            r_days_4_5 <= '0;
            r_day_6    <= '0;
            r_control  <= '0;
            r_day_sp   <= '0;
            r_night_sp <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wdns_pkg::REG_DAYS_0_1: r_days_0_1 <= i_cfg_data;
                wdns_pkg::REG_DAYS_2_3: r_days_2_3 <= i_cfg_data;
                wdns_pkg::REG_DAYS_4_5: r_days_4_5 <= i_cfg_data;
                wdns_pkg::REG_DAY_6:    r_day_6    <= i_cfg_data[21:0];
                wdns_pkg::REG_CONTROL:  r_control  <= i_cfg_data[10:0];
                wdns_pkg::REG_DAY_SP:   r_day_sp   <= i_cfg_data[39:0];
                wdns_pkg::REG_NIGHT_SP: r_night_sp <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // Capture the word, then walk the years
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year <= in_year;
            r_yidx <= wdns_pkg::BASE_YEAR;
            r_res  <= wdns_pkg::f_mod7(doy);
            r_now  <= now_in;
        end else if (i_cmd.step) begin
            r_yidx <= r_yidx + 7'd1;
            r_res  <= step_res;
        end
    end

    // Stored mode; held in manual mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_night <= 1'b0;
        end else if (i_cmd.finish && !manual) begin
            r_night <= next_night;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_wday     <= r_res + 3'd1;
            r_out_night    <= manual ? r_night : next_night;
            r_out_changed  <= changed;
            r_out_temp_upd <= changed && r_control[8];
            r_out_temp     <= (changed && r_control[8]) ? sp[15:0] : 16'd0;
            r_out_fan_upd  <= changed && r_control[9];
            r_out_fan      <= (changed && r_control[9]) ? sp[31:16] : 16'd0;
            r_out_cm_upd   <= changed && r_control[10];
            r_out_cm       <= (changed && r_control[10]) ? sp[39:32] : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_cm, r_out_cm_upd, r_out_fan, r_out_fan_upd,
                          r_out_temp, r_out_temp_upd, r_out_changed, r_out_night,
                          r_out_wday};

    // Residue stays a valid weekday index
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.load) |-> (r_res != 3'd7))
        else $error("weekday residue out of range");

    // A reported change matches the stored mode flip
    a_change_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out_changed == (r_night != $past(r_night))))
        else $error("mode change flag disagrees with stored mode");

    // Output night bit reflects the stored mode
    a_night_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out_night == r_night))
        else $error("night bit differs from stored mode");

endmodule

// ----- src/weekly_day_night_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// weekly_day_night_scheduler_unit
// Weekly day/night scheduler: derives the weekday of a calendar time,
// decides day or night from the weekday schedule and emits the setpoints
// of the new mode on a change.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   calendar time word
//  m_axis    out        m_axis_tvalid / m_axis_tready   weekday, mode, setpoints
//  cfg       in         i_cfg_we (no wait)              i_cfg_index, i_cfg_data
//
//  A word is captured on accept; the year walk then adds one whole year per
//  step through the mod-7 residue, from year 8 up to the word's year, and a
//  last step decides and loads the output register.
//  Reset (synchronous, active low) clears config, output valid and mode to day.
//  A stalled output holds the result; the next word is already taken and
//  walks while the result waits, and is finished once the output is free.
// ----------------------------------------------------------------------------
module weekly_day_night_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [43:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year[6:0], month[10:7], day_of_month[15:11], hour[20:16], minute[26:21]
    input  logic [31:0] s_axis_tdata,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // weekday[2:0], night_mode[3], mode_changed[4], temp_update[5],
    // temp_setpoint[21:6], fan_update[22], fan_speed[38:23],
    // ctrl_mode_update[39], ctrl_mode[47:40]
    output logic [47:0] m_axis_tdata
);

    wdns_pkg::t_cmd    cmd;
    wdns_pkg::t_status status;

    wdns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wdns_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weekly day/night scheduler. Calendar time words
// go in on the input stream and every accepted word is run through a
// predictor of the weekday and day/night decision. Result words from the
// output stream are compared field by field, in order. Directed words cover
// leap days, out-of-range fields, empty windows and manual mode; random
// phases reprogram every register and mix valid dates with noise, while both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Index past the register list: the block must ignore the write
    localparam logic [wdns_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned MONTH_DAYS [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned DRAIN_CYCLES = 130;

    // Input word, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0] pad;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] dom;
        logic [3:0] month;
        logic [6:0] year;
    } t_calendar_word;

    // Result word, lowest field in the lowest bits
    typedef struct packed {
        logic [7:0]         ctrl_mode;
        logic               ctrl_mode_update;
        logic [15:0]        fan_speed;
        logic               fan_update;
        logic signed [15:0] temp_setpoint;
        logic               temp_update;
        logic               mode_changed;
        logic               night_mode;
        logic [2:0]         weekday;
    } t_sched_result;

    // Predicts result words and checks them in arrival order
    class t_schedule_scoreboard;
        logic [43:0]   regs [7];
        bit            night_flag;
        t_sched_result expected_outputs [$];
        int unsigned   errors;
        int unsigned   results;
        int unsigned   switches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            night_flag = 1'b0;
            errors     = 0;
            results    = 0;
            switches   = 0;
        endfunction

        // Keep only the bits each register holds
        function void write_reg(logic [wdns_pkg::CFG_IDX_W-1:0] idx, logic [43:0] val);
            case (idx)
                wdns_pkg::REG_DAYS_0_1, wdns_pkg::REG_DAYS_2_3,
                wdns_pkg::REG_DAYS_4_5:  regs[idx] = val;
                wdns_pkg::REG_DAY_6:     regs[idx] = {22'd0, val[21:0]};
                wdns_pkg::REG_CONTROL:   regs[idx] = {33'd0, val[10:0]};
                wdns_pkg::REG_DAY_SP,
                wdns_pkg::REG_NIGHT_SP:  regs[idx] = {4'd0, val[39:0]};
                default: ;
            endcase
        endfunction

        // Day of year plus whole years since 2008, folded to 1 Monday .. 7 Sunday
        function int unsigned weekday_of(int unsigned yr, int unsigned mo, int unsigned dy);
            int unsigned count;
            int unsigned m;
            int unsigned y;
            bit found;
            count = 0;
            found = 1'b0;
            for (m = 1; m <= 12; m++) begin
                if (!found) begin
                    if (mo == m) begin
                        count += dy;
                        found = 1'b1;
                    end else begin
                        count += MONTH_DAYS[m-1];
                        if (yr % 4 == 0 && m == 2) count++;
                    end
                end
            end
            for (y = 8; y < yr; y++) count += (y % 4 == 0) ? 366 : 365;
            return count % 7 + 1;
        endfunction

        // Work out the result of one accepted time word
        function void note_time(t_calendar_word t);
            t_sched_result r;
            int unsigned   wd;
            int unsigned   idx;
            int unsigned   now;
            int unsigned   start;
            int unsigned   stop;
            logic [43:0]   packed_days;
            logic [21:0]   win;
            logic [39:0]   sp;
            bit            next;
            r   = '0;
            wd  = weekday_of(t.year, t.month, t.dom);
            idx = wd - 1;
            r.weekday = wd[2:0];
            if (!regs[wdns_pkg::REG_CONTROL][0]) begin
                packed_days = regs[idx/2] >> ((idx % 2) * 22);
                win   = packed_days[21:0];
                start = 32'(win[10:0]);
                stop  = 32'(win[21:11]);
                now   = t.hour * 60 + t.minute;
                next  = !(regs[wdns_pkg::REG_CONTROL][1+idx] && now >= start && now < stop);
                if (next != night_flag) begin
                    sp = next ? regs[wdns_pkg::REG_NIGHT_SP][39:0]
                              : regs[wdns_pkg::REG_DAY_SP][39:0];
                    r.mode_changed = 1'b1;
                    if (regs[wdns_pkg::REG_CONTROL][8]) begin
                        r.temp_update   = 1'b1;
                        r.temp_setpoint = sp[15:0];
                    end
                    if (regs[wdns_pkg::REG_CONTROL][9]) begin
                        r.fan_update = 1'b1;
                        r.fan_speed  = sp[31:16];
                    end
                    if (regs[wdns_pkg::REG_CONTROL][10]) begin
                        r.ctrl_mode_update = 1'b1;
                        r.ctrl_mode        = sp[39:32];
                    end
                end
                night_flag = next;
            end
            r.night_mode = night_flag;
            expected_outputs.push_back(r);
        endfunction

        function void cmp_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare a result word with the oldest prediction
        function void check_result(t_sched_result got);
            t_sched_result want;
            if (expected_outputs.size() == 0) begin
                $error("result word %h arrived with nothing expected", got);
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            results++;
            if (got.mode_changed) switches++;
            cmp_field("weekday", want.weekday, got.weekday);
            cmp_field("night_mode", want.night_mode, got.night_mode);
            cmp_field("mode_changed", want.mode_changed, got.mode_changed);
            cmp_field("temp_update", want.temp_update, got.temp_update);
            cmp_field("temp_setpoint", want.temp_setpoint, got.temp_setpoint);
            cmp_field("fan_update", want.fan_update, got.fan_update);
            cmp_field("fan_speed", want.fan_speed, got.fan_speed);
            cmp_field("ctrl_mode_update", want.ctrl_mode_update, got.ctrl_mode_update);
            cmp_field("ctrl_mode", want.ctrl_mode, got.ctrl_mode);
        endfunction

        function int unsigned pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [wdns_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [43:0]                    i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [47:0]                    m_axis_tdata;

    t_schedule_scoreboard sched_sb = new();
    bit          calm        = 1'b0;
    int unsigned words_sent  = 0;
    int unsigned cfg_writes  = 0;

    weekly_day_night_scheduler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Stall the output side at random unless in a calm stretch
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 13);
    end

    // Watch both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sched_sb.note_time(t_calendar_word'(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sched_sb.check_result(t_sched_result'(m_axis_tdata));
            end
        end
    end

    // Hard stop if the block hangs
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Write one register; called at a falling edge, returns at the next one
    task automatic program_reg(logic [wdns_pkg::CFG_IDX_W-1:0] idx, logic [43:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        sched_sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hold until every predicted word has come back
    task automatic wait_idle();
        while (sched_sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Offer one time word, idling first now and then
    task automatic send_word(t_calendar_word w);
        if (!calm && $urandom_range(99) < 13) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = w;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        @(negedge i_clk);
        // Drop valid so a taken word is never offered again
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_cal(int unsigned y, int unsigned mo, int unsigned d,
                            int unsigned h, int unsigned mi);
        t_calendar_word w;
        w = '0;
        w.year   = 7'(y);
        w.month  = 4'(mo);
        w.dom    = 5'(d);
        w.hour   = 5'(h);
        w.minute = 6'(mi);
        send_word(w);
    endtask

    // Mostly in range, sometimes anything the field can hold
    function automatic int unsigned pick(int unsigned lo, int unsigned hi, int unsigned full);
        return ($urandom_range(9) == 0) ? $urandom_range(0, full) : $urandom_range(lo, hi);
    endfunction

    // One day's {end, start}: mostly a real window, sometimes empty or extreme
    function automatic logic [21:0] rand_window();
        logic [10:0] start;
        logic [10:0] stop;
        case ($urandom_range(9))
            0: begin
                start = 11'($urandom_range(600, 2047));
                stop  = 11'($urandom_range(0, start));
            end
            1: begin
                start = 11'($urandom);
                stop  = 11'($urandom);
            end
            2: begin
                start = 11'd0;
                stop  = 11'd2047;
            end
            default: begin
                start = 11'($urandom_range(0, 1300));
                stop  = 11'($urandom_range(start + 1, 1439));
            end
        endcase
        return {stop, start};
    endfunction

    // Reprogram every register with random content
    task automatic random_setup();
        logic [6:0] enables;
        enables = 7'($urandom | $urandom);
        program_reg(wdns_pkg::REG_DAYS_0_1, {rand_window(), rand_window()});
        program_reg(wdns_pkg::REG_DAYS_2_3, {rand_window(), rand_window()});
        program_reg(wdns_pkg::REG_DAYS_4_5, {rand_window(), rand_window()});
        program_reg(wdns_pkg::REG_DAY_6, {22'($urandom), rand_window()});
        program_reg(wdns_pkg::REG_CONTROL, {33'($urandom), 3'($urandom), enables,
                                            1'($urandom_range(5) == 0)});
        program_reg(wdns_pkg::REG_DAY_SP, {12'($urandom), $urandom});
        program_reg(wdns_pkg::REG_NIGHT_SP, {12'($urandom), $urandom});
        if ($urandom_range(3) == 0) program_reg(REG_UNUSED, {12'($urandom), $urandom});
    endtask

    initial begin
        int unsigned phase;
        int unsigned k;
        logic [21:0] win_std;
        win_std = {11'd1200, 11'd480};

        // Hold reset, then release at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: everything disabled, so the first word drops to night
        send_cal(8, 1, 1, 0, 0);
        send_cal(0, 1, 1, 12, 0);

        // Working hours 8:00-20:00, Saturday whole range, Sunday empty window
        wait_idle();
        program_reg(wdns_pkg::REG_DAYS_0_1, {win_std, win_std});
        program_reg(wdns_pkg::REG_DAYS_2_3, {win_std, win_std});
        program_reg(wdns_pkg::REG_DAYS_4_5, {11'd2047, 11'd0, win_std});
        program_reg(wdns_pkg::REG_DAY_6, {22'd0, 11'd1000, 11'd1000});
        program_reg(wdns_pkg::REG_CONTROL, {33'd0, 3'b111, 7'h7F, 1'b0});
        program_reg(wdns_pkg::REG_DAY_SP, {4'h0, 8'hFF, 16'hFFFF, 16'h8000});
        program_reg(wdns_pkg::REG_NIGHT_SP, {4'h0, 8'h00, 16'h0000, 16'h7FFF});
        send_cal(8, 1, 1, 10, 0);
        send_cal(8, 1, 1, 20, 0);
        send_cal(8, 1, 1, 7, 59);
        send_cal(8, 1, 1, 8, 0);
        send_cal(8, 2, 29, 12, 0);
        send_cal(8, 3, 1, 12, 0);
        send_cal(9, 3, 1, 12, 0);
        send_cal(0, 1, 0, 0, 0);
        send_cal(7, 12, 31, 23, 59);
        send_cal(127, 15, 31, 31, 63);
        send_cal(99, 0, 5, 12, 0);
        send_cal(20, 13, 1, 12, 0);
        send_cal(8, 1, 6, 12, 0);
        send_cal(8, 1, 5, 31, 63);
        send_cal(8, 1, 7, 12, 0);

        // Manual mode with every register at all ones; the unused index is ignored
        wait_idle();
        program_reg(wdns_pkg::REG_DAYS_0_1, '1);
        program_reg(wdns_pkg::REG_DAYS_2_3, '1);
        program_reg(wdns_pkg::REG_DAYS_4_5, '1);
        program_reg(wdns_pkg::REG_DAY_6, '1);
        program_reg(wdns_pkg::REG_CONTROL, '1);
        program_reg(wdns_pkg::REG_DAY_SP, '1);
        program_reg(wdns_pkg::REG_NIGHT_SP, '1);
        program_reg(REG_UNUSED, '0);
        send_cal(8, 1, 1, 10, 0);
        send_cal(50, 6, 15, 3, 30);

        // Automatic with no day enabled: forced to night
        wait_idle();
        program_reg(wdns_pkg::REG_CONTROL, {33'd0, 3'b101, 7'h00, 1'b0});
        send_cal(8, 1, 1, 10, 0);
        send_cal(64, 8, 16, 16, 32);

        // Random phases, each with fresh settings
        for (phase = 0; phase < 6; phase++) begin
            wait_idle();
            random_setup();
            calm = (phase == 2);
            for (k = 0; k < 100; k++) begin
                if (phase == 4 && k == 50) begin
                    s_axis_tvalid = 1'b0;
                    while (sched_sb.pending() != 0) @(negedge i_clk);
                end
                send_cal(($urandom_range(9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(8, 99),
                         pick(1, 12, 15), pick(1, 31, 31),
                         pick(0, 23, 31), pick(0, 59, 63));
            end
        end
        calm = 1'b0;
        s_axis_tvalid = 1'b0;

        // Drain, then allow for a stray late word
        while (sched_sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d time words, checked %0d result words, %0d register writes",
                 words_sent, sched_sb.results, cfg_writes);
        $display("Saw %0d day/night switches across leap, out-of-range and manual cases",
                 sched_sb.switches);
        if (sched_sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
